// File: hdl/target_box_angle_framer_top_assert.svh
// Assertion helpers for the target box angle framer.
`ifndef TARGET_BOX_ANGLE_FRAMER_TOP_ASSERT_SVH
`define TARGET_BOX_ANGLE_FRAMER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define TBAF_ASSERT_IMP(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
`define TBAF_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define TBAF_ASSERT_IMP(label, clk, rstn, a, b)
`define TBAF_ASSERT_NEXT(label, clk, rstn, a, b)
`endif

`endif

// File: hdl/tbaf_pkg.sv
`default_nettype none
package tbaf_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int CHAIN_LEN    = 32;
    localparam int IDX_W        = 5;
    localparam int XW           = 21;
    localparam int ZW           = 31;
    localparam int ANGLE_FRAC   = 12;

    localparam logic [7:0]  FRAME_START = 8'h73;
    localparam logic [7:0]  FRAME_END   = 8'h65;
    localparam logic [15:0] DIST_SAT    = 16'h7FFF;
    localparam logic [3:0]  LAST_POS    = 4'd13;

    localparam logic [2:0] REG_CENTRE_X     = 3'd0;
    localparam logic [2:0] REG_CENTRE_Y     = 3'd1;
    localparam logic [2:0] REG_FOCAL        = 3'd2;
    localparam logic [2:0] REG_DIST_CONST   = 3'd3;
    localparam logic [2:0] REG_PITCH_OFFSET = 3'd4;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } lane_t;

    typedef struct packed {
        logic        valid;
        lane_t       yaw;
        lane_t       pitch;
        logic [15:0] rem;
        logic [31:0] qd;
        logic [15:0] den;
        logic        hzero;
    } cell_t;

    // Arctangent of 2^-i in 1/4096 millidegree, zero past the last rotation.
    function automatic logic signed [ZW-1:0] atan_lut(input logic [IDX_W-1:0] i);
        logic signed [ZW-1:0] a;
        case (i)
            5'd0:  a = 31'sd184320000;
            5'd1:  a = 31'sd108810450;
            5'd2:  a = 31'sd57492453;
            5'd3:  a = 31'sd29184067;
            5'd4:  a = 31'sd14648666;
            5'd5:  a = 31'sd7331474;
            5'd6:  a = 31'sd3666632;
            5'd7:  a = 31'sd1833428;
            5'd8:  a = 31'sd916728;
            5'd9:  a = 31'sd458366;
            5'd10: a = 31'sd229183;
            5'd11: a = 31'sd114592;
            5'd12: a = 31'sd57296;
            5'd13: a = 31'sd28648;
            5'd14: a = 31'sd14324;
            5'd15: a = 31'sd7162;
            5'd16: a = 31'sd3581;
            5'd17: a = 31'sd1790;
            5'd18: a = 31'sd895;
            5'd19: a = 31'sd448;
            5'd20: a = 31'sd224;
            5'd21: a = 31'sd112;
            5'd22: a = 31'sd56;
            5'd23: a = 31'sd28;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// File: hdl/tbaf_cell.sv
`default_nettype none
// One cell of the chain: a vectoring rotation on each angle lane (first
// cells only) and one restoring division step, registered.
module tbaf_cell (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        adv,
    input  wire logic [tbaf_pkg::IDX_W-1:0]  step,
    input  wire tbaf_pkg::cell_t             cell_in,
    output tbaf_pkg::cell_t                  cell_out
);

    function automatic tbaf_pkg::lane_t rotate(input tbaf_pkg::lane_t l,
                                               input logic [tbaf_pkg::IDX_W-1:0] s);
        tbaf_pkg::lane_t r;
        logic signed [tbaf_pkg::XW-1:0] xs;
        logic signed [tbaf_pkg::XW-1:0] ys;
        logic signed [tbaf_pkg::ZW-1:0] a;
        r  = l;
        xs = l.x >>> s;
        ys = l.y >>> s;
        a  = tbaf_pkg::atan_lut(s);
        if (l.y > 0) begin
            r.x = l.x + ys;
            r.y = l.y - xs;
            r.z = l.z + a;
        end else if (l.y < 0) begin
            r.x = l.x - ys;
            r.y = l.y + xs;
            r.z = l.z - a;
        end
        return r;
    endfunction

    tbaf_pkg::cell_t cell_next;
    logic [16:0]     trial;
    logic            qbit;
    logic            valid_reg;
    tbaf_pkg::cell_t data_reg;

    always_comb begin
        cell_next = cell_in;
        if (step < tbaf_pkg::IDX_W'(tbaf_pkg::CORDIC_STEPS)) begin
            cell_next.yaw   = rotate(cell_in.yaw, step);
            cell_next.pitch = rotate(cell_in.pitch, step);
        end
        trial = {cell_in.rem, cell_in.qd[31]};
        qbit  = (trial >= {1'b0, cell_in.den});
        cell_next.rem = qbit ? 16'(trial - {1'b0, cell_in.den}) : trial[15:0];
        cell_next.qd  = {cell_in.qd[30:0], qbit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= cell_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= cell_next;
        end
    end

    always_comb begin
        cell_out       = data_reg;
        cell_out.valid = valid_reg;
    end

endmodule
`default_nettype wire

// File: hdl/tbaf_framer.sv
`default_nettype none
// Finishes the angles and the distance and sends the 14-byte frame.
module tbaf_framer (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire tbaf_pkg::cell_t    tail,
    input  wire logic [17:0]        pitch_offset,
    output logic                    load,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [7:0]              m_tdata,   // frame_byte
    output logic                    m_tlast    // frame_last
);

    function automatic logic [15:0] trunc16(input logic signed [31:0] v);
        logic [31:0] m;
        if (v[31]) begin
            m = -v;
            m = m >> tbaf_pkg::ANGLE_FRAC;
            m = -m;
        end else begin
            m = v >> tbaf_pkg::ANGLE_FRAC;
        end
        return m[15:0];
    endfunction

    logic        busy_reg;
    logic [3:0]  cnt_reg;
    logic [15:0] yaw_reg;
    logic [15:0] pitch_reg;
    logic [15:0] dist_reg;
    logic        done;
    logic signed [31:0] pitch_full;

    assign done = busy_reg && m_tready && (cnt_reg == tbaf_pkg::LAST_POS);
    assign load = tail.valid && (!busy_reg || done);

    // Pitch is negated after the offset, scaled to the angle fraction, is removed.
    assign pitch_full = 32'sd0 - (32'(tail.pitch.z)
                        - {{2{pitch_offset[17]}}, pitch_offset, 12'b0});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (done) begin
            busy_reg <= 1'b0;
        end else if (busy_reg && m_tready) begin
            cnt_reg <= cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            yaw_reg   <= trunc16(32'(tail.yaw.z));
            pitch_reg <= trunc16(pitch_full);
            dist_reg  <= tail.hzero ? tbaf_pkg::DIST_SAT : tail.qd[15:0];
        end
    end

    always_comb begin
        case (cnt_reg) inside
            4'd0:         m_tdata = tbaf_pkg::FRAME_START;
            4'd1, 4'd2:   m_tdata = {8{yaw_reg[15]}};
            4'd3:         m_tdata = yaw_reg[15:8];
            4'd4:         m_tdata = yaw_reg[7:0];
            4'd5, 4'd6:   m_tdata = {8{pitch_reg[15]}};
            4'd7:         m_tdata = pitch_reg[15:8];
            4'd8:         m_tdata = pitch_reg[7:0];
            4'd9, 4'd10:  m_tdata = {8{dist_reg[15]}};
            4'd11:        m_tdata = dist_reg[15:8];
            4'd12:        m_tdata = dist_reg[7:0];
            default:      m_tdata = tbaf_pkg::FRAME_END;
        endcase
    end

    assign m_tvalid = busy_reg;
    assign m_tlast  = (cnt_reg == tbaf_pkg::LAST_POS);

endmodule
`default_nettype wire

// File: hdl/target_box_angle_framer_top.sv
`default_nettype none
// Channel   Dir   Beat contents (low bits first)
// s_        in    box_x, box_y, box_width, box_height (16 bits each)
// m_        out   frame_byte (tdata), frame_last (tlast)
// APB       in    centre_x, centre_y, focal_length, distance_constant, pitch_offset
//
// Each box passes a chain of 32 cells, one per cycle while the chain does not
// stall; the first 24 run the angle rotations and all 32 run one quotient bit
// of the distance division. A frame on the output is 14 bytes. All-zero boxes
// are dropped at the input. Reset is synchronous; the chain stalls only while
// its last cell holds a box and the serializer is still busy with a frame.
module target_box_angle_framer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // box_x, box_y, box_width, box_height
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // frame_byte
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

`include "target_box_angle_framer_top_assert.svh"

    logic [15:0] centre_x_reg;
    logic [15:0] centre_y_reg;
    logic [15:0] focal_reg;
    logic [31:0] dist_const_reg;
    logic [17:0] pitch_offset_reg;
    logic        cfg_wr;
    logic        adv;
    logic        load;
    logic [15:0] box_x, box_y, box_w, box_h;

    tbaf_pkg::cell_t link [tbaf_pkg::CHAIN_LEN+1];

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centre_x_reg     <= 16'd5120;
            centre_y_reg     <= 16'd3840;
            focal_reg        <= 16'd16000;
            dist_const_reg   <= '0;
            pitch_offset_reg <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                tbaf_pkg::REG_CENTRE_X:     centre_x_reg     <= pwdata[15:0];
                tbaf_pkg::REG_CENTRE_Y:     centre_y_reg     <= pwdata[15:0];
                tbaf_pkg::REG_FOCAL:        focal_reg        <= pwdata[15:0];
                tbaf_pkg::REG_DIST_CONST:   dist_const_reg   <= pwdata;
                tbaf_pkg::REG_PITCH_OFFSET: pitch_offset_reg <= pwdata[17:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            tbaf_pkg::REG_CENTRE_X:     prdata = {16'b0, centre_x_reg};
            tbaf_pkg::REG_CENTRE_Y:     prdata = {16'b0, centre_y_reg};
            tbaf_pkg::REG_FOCAL:        prdata = {16'b0, focal_reg};
            tbaf_pkg::REG_DIST_CONST:   prdata = dist_const_reg;
            tbaf_pkg::REG_PITCH_OFFSET: prdata = {{14{pitch_offset_reg[17]}},
                                                  pitch_offset_reg};
            default:                    prdata = '0;
        endcase
    end

    assign box_x = s_tdata[15:0];
    assign box_y = s_tdata[31:16];
    assign box_w = s_tdata[47:32];
    assign box_h = s_tdata[63:48];

    assign adv      = !link[tbaf_pkg::CHAIN_LEN].valid || load;
    assign s_tready = adv;

    // Offsets are kept doubled so the half width and half height stay exact.
    always_comb begin
        link[0].valid   = s_tvalid && (s_tdata != 64'd0);
        link[0].yaw.x   = {4'b0, focal_reg, 1'b0};
        link[0].yaw.y   = {4'b0, box_x, 1'b0} + {5'b0, box_w} - {4'b0, centre_x_reg, 1'b0};
        link[0].yaw.z   = '0;
        link[0].pitch.x = {4'b0, focal_reg, 1'b0};
        link[0].pitch.y = {4'b0, box_y, 1'b0} + {5'b0, box_h} - {4'b0, centre_y_reg, 1'b0};
        link[0].pitch.z = '0;
        link[0].rem     = '0;
        link[0].qd      = dist_const_reg;
        link[0].den     = box_h;
        link[0].hzero   = (box_h == 16'd0);
    end

    for (genvar g = 0; g < tbaf_pkg::CHAIN_LEN; g++) begin : g_chain
        tbaf_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .step     (tbaf_pkg::IDX_W'(g)),
            .cell_in  (link[g]),
            .cell_out (link[g+1])
        );
    end

    tbaf_framer u_framer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tail         (link[tbaf_pkg::CHAIN_LEN]),
        .pitch_offset (pitch_offset_reg),
        .load         (load),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

    `TBAF_ASSERT_IMP(a_last_is_end, aclk, aresetn, m_tvalid && m_tlast, m_tdata == tbaf_pkg::FRAME_END)
    `TBAF_ASSERT_IMP(a_first_is_start, aclk, aresetn, $rose(m_tvalid), m_tdata == tbaf_pkg::FRAME_START)
    `TBAF_ASSERT_IMP(a_stall_needs_tail, aclk, aresetn, !s_tready, link[tbaf_pkg::CHAIN_LEN].valid && m_tvalid)
    `TBAF_ASSERT_NEXT(a_load_starts_frame, aclk, aresetn, load, m_tvalid && m_tdata == tbaf_pkg::FRAME_START)

endmodule
`default_nettype wire
